// ----- hdl/pptm_pkg.sv -----
// Shared types and codes for the page pool and table mapper.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pptm_pkg;

   localparam int FRAME_W   = 27;
   localparam int INDEX_W   = 9;
   localparam int ATTR_W    = 10;
   localparam int VADDR_W   = 48;
   localparam int ENTRY_W   = 39;
   localparam int HIGH_W    = 28;

   localparam logic [1:0] TYPE_BLOCK = 2'b01;
   localparam logic [1:0] TYPE_TABLE = 2'b11;

   typedef enum logic [1:0] {
      CMD_FREE  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_MAP   = 2'd2,
      CMD_UNMAP = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK     = 3'd0,
      STS_NOMEM  = 3'd1,
      STS_RANGE  = 3'd2,
      STS_MAPPED = 3'd3,
      STS_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_CHK,
      S_CLEAR,
      S_LINK,
      S_WALK_RD,
      S_WALK_CHK,
      S_DONE
   } state_type;

   typedef enum logic {
      CSR_POOL_LOW  = 1'b0,
      CSR_POOL_HIGH = 1'b1
   } csr_type;

endpackage

// ----- hdl/page_pool_and_table_mapper_unit.sv -----
// Top level of the page pool and table mapper: command sequencer, free stack.
// Depends on pptm_pkg and pptm_table_ram.
`timescale 1ns / 1ps

// The unit takes one command item at a time and returns exactly one result
// item for it. An allocation that succeeds clears the 512 entries of the new
// table one entry per cycle through the single write port of the table RAM.
// A map walks three levels, each a registered read of the table RAM, and
// clears every table that it allocates on the way.
// A map that fails its bound checks returns without a walk. The table RAM
// is not cleared after reset: a table is only defined once an allocation
// has cleared it. The result is held in an output register, so the next
// command can be taken while the previous result waits.

module page_pool_and_table_mapper_unit #(
   parameter int NUM_PAGES  = 64,
   parameter int PAGE_SHIFT = 21
) (
   input  logic           clock,
   input  logic           reset,
   // Command items.
   input  logic           req_tvalid,
   output logic           req_tready,
   // tdata from bit 0: frame[26:0], root_frame[53:27], vaddr[101:54],
   // attribute[111:102].
   input  logic [111:0]   req_tdata,
   // tuser from bit 0: command[1:0].
   input  logic [1:0]     req_tuser,
   // Result items.
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // tdata from bit 0: status[2:0], frame_out[29:3], zero[31:30].
   output logic [31:0]    rsp_tdata,
   // Configuration writes.
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [27:0]    csr_wdata
);

   localparam int FB    = $clog2(NUM_PAGES);
   localparam int CW    = $clog2(NUM_PAGES + 1);
   localparam int IW    = pptm_pkg::INDEX_W;
   localparam int AW    = FB + IW;
   localparam int DEPTH = NUM_PAGES * (1 << IW);
   localparam int FW    = pptm_pkg::FRAME_W;
   localparam int EW    = pptm_pkg::ENTRY_W;

   pptm_pkg::state_type  state_ff, state_in;
   pptm_pkg::cmd_type    cmd_ff, cmd_in;
   pptm_pkg::status_type res_status_ff, res_status_in;
   logic [FW-1:0]        res_frame_ff, res_frame_in;
   logic [FW-1:0]        frame_ff, frame_in;
   logic [FW-1:0]        root_ff, root_in;
   logic [pptm_pkg::VADDR_W-1:0] va_ff, va_in;
   logic [pptm_pkg::ATTR_W-1:0]  attr_ff, attr_in;
   logic [1:0]           level_ff, level_in;
   logic [FB-1:0]        cur_ff, cur_in;
   logic [FB-1:0]        new_ff, new_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [FW-1:0]        low_ff;
   logic [pptm_pkg::HIGH_W-1:0] high_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pptm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [FW-1:0]        rsp_frame_ff, rsp_frame_in;

   // Free stack memory.
   logic [FW-1:0]        stack_mem [NUM_PAGES];
   logic [FW-1:0]        stk_rdata_ff;
   logic                 stk_we;
   logic [FB-1:0]        stk_waddr, stk_raddr;
   logic [FW-1:0]        stk_wdata;

   // Table RAM ports.
   logic                 tbl_we;
   logic [AW-1:0]        tbl_waddr, tbl_raddr;
   logic [EW-1:0]        tbl_wdata, tbl_rdata;

   logic [63:0]          va_wide;
   logic [IW-1:0]        idx_l0, idx_l1, idx_l2, idx_sel;
   logic [FW-1:0]        push_frame, entry_frame;
   pptm_pkg::status_type push_status;

   function automatic logic in_pool(input logic [FW-1:0] f,
                                    input logic [FW-1:0] lo,
                                    input logic [pptm_pkg::HIGH_W-1:0] hi);
      in_pool = (f >= lo) && ({1'b0, f} < hi) && (f < FW'(NUM_PAGES));
   endfunction

   assign va_wide = {16'd0, va_ff};
   assign idx_l0  = va_wide[PAGE_SHIFT + 2*IW +: IW];
   assign idx_l1  = va_wide[PAGE_SHIFT + IW +: IW];
   assign idx_l2  = va_wide[PAGE_SHIFT +: IW];

   always_comb begin
      unique case (level_ff)
         2'd0:    idx_sel = idx_l0;
         2'd1:    idx_sel = idx_l1;
         default: idx_sel = idx_l2;
      endcase
   end

   assign entry_frame = tbl_rdata[EW-1:12];
   // Free pushes the command's frame; unmap pushes the frame of the leaf entry.
   assign push_frame  = (state_ff == pptm_pkg::S_EXEC) ? frame_ff : entry_frame;

   always_comb begin
      if (!in_pool(push_frame, low_ff, high_ff)) begin
         push_status = pptm_pkg::STS_RANGE;
      end else if (count_ff >= CW'(NUM_PAGES)) begin
         push_status = pptm_pkg::STS_FULL;
      end else begin
         push_status = pptm_pkg::STS_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      frame_in      = frame_ff;
      root_in       = root_ff;
      va_in         = va_ff;
      attr_in       = attr_ff;
      level_in      = level_ff;
      cur_in        = cur_ff;
      new_in        = new_ff;
      slot_in       = slot_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      stk_we        = 1'b0;
      stk_waddr     = count_ff[FB-1:0];
      stk_wdata     = push_frame;
      stk_raddr     = FB'(count_ff - CW'(1));
      tbl_we        = 1'b0;
      tbl_waddr     = slot_ff;
      tbl_wdata     = '0;
      tbl_raddr     = {cur_ff, idx_sel};
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;

      unique case (state_ff)
         pptm_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = pptm_pkg::cmd_type'(req_tuser);
               frame_in = req_tdata[26:0];
               root_in  = req_tdata[53:27];
               va_in    = req_tdata[101:54];
               attr_in  = req_tdata[111:102];
               state_in = pptm_pkg::S_EXEC;
            end
         end
         pptm_pkg::S_EXEC: begin
            res_frame_in = '0;
            level_in     = 2'd0;
            cur_in       = root_ff[FB-1:0];
            unique case (cmd_ff)
               pptm_pkg::CMD_FREE: begin
                  res_status_in = push_status;
                  if (push_status == pptm_pkg::STS_OK) begin
                     stk_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  state_in = pptm_pkg::S_DONE;
               end
               pptm_pkg::CMD_ALLOC: begin
                  if (count_ff == '0) begin
                     res_status_in = pptm_pkg::STS_NOMEM;
                     state_in      = pptm_pkg::S_DONE;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = pptm_pkg::S_POP_CHK;
                  end
               end
               pptm_pkg::CMD_MAP: begin
                  if (({1'b0, frame_ff} + 28'd1) > high_ff ||
                      root_ff >= FW'(NUM_PAGES)) begin
                     res_status_in = pptm_pkg::STS_RANGE;
                     state_in      = pptm_pkg::S_DONE;
                  end else begin
                     state_in = pptm_pkg::S_WALK_RD;
                  end
               end
               default: begin
                  if (root_ff >= FW'(NUM_PAGES)) begin
                     res_status_in = pptm_pkg::STS_RANGE;
                     state_in      = pptm_pkg::S_DONE;
                  end else begin
                     state_in = pptm_pkg::S_WALK_RD;
                  end
               end
            endcase
         end
         pptm_pkg::S_POP_CHK: begin
            // A popped frame that has left the pool is dropped.
            if (!in_pool(stk_rdata_ff, low_ff, high_ff)) begin
               res_status_in = pptm_pkg::STS_RANGE;
               state_in      = pptm_pkg::S_DONE;
            end else begin
               new_in   = stk_rdata_ff[FB-1:0];
               clr_in   = '0;
               state_in = pptm_pkg::S_CLEAR;
            end
         end
         pptm_pkg::S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = {new_ff, clr_ff};
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == {IW{1'b1}}) begin
               if (cmd_ff == pptm_pkg::CMD_ALLOC) begin
                  res_status_in = pptm_pkg::STS_OK;
                  res_frame_in  = FW'(new_ff);
                  state_in      = pptm_pkg::S_DONE;
               end else begin
                  state_in = pptm_pkg::S_LINK;
               end
            end
         end
         pptm_pkg::S_LINK: begin
            tbl_we    = 1'b1;
            tbl_wdata = {FW'(new_ff), attr_ff, pptm_pkg::TYPE_TABLE};
            cur_in    = new_ff;
            level_in  = level_ff + 2'd1;
            state_in  = pptm_pkg::S_WALK_RD;
         end
         pptm_pkg::S_WALK_RD: begin
            slot_in  = {cur_ff, idx_sel};
            state_in = pptm_pkg::S_WALK_CHK;
         end
         pptm_pkg::S_WALK_CHK: begin
            res_status_in = pptm_pkg::STS_OK;
            state_in      = pptm_pkg::S_DONE;
            if (level_ff != 2'd2) begin
               if (tbl_rdata[0]) begin
                  // Any valid upper-level entry is followed as a table.
                  if (entry_frame >= FW'(NUM_PAGES)) begin
                     res_status_in = pptm_pkg::STS_RANGE;
                  end else begin
                     cur_in   = entry_frame[FB-1:0];
                     level_in = level_ff + 2'd1;
                     state_in = pptm_pkg::S_WALK_RD;
                  end
               end else if (cmd_ff == pptm_pkg::CMD_MAP) begin
                  if (count_ff == '0) begin
                     res_status_in = pptm_pkg::STS_NOMEM;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = pptm_pkg::S_POP_CHK;
                  end
               end
            end else if (cmd_ff == pptm_pkg::CMD_MAP) begin
               if (tbl_rdata[0]) begin
                  res_status_in = pptm_pkg::STS_MAPPED;
               end else begin
                  tbl_we    = 1'b1;
                  tbl_wdata = {frame_ff, attr_ff, pptm_pkg::TYPE_BLOCK};
               end
            end else if (tbl_rdata[0]) begin
               res_status_in = push_status;
               if (push_status == pptm_pkg::STS_OK) begin
                  stk_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  tbl_we   = 1'b1;
               end
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               state_in      = pptm_pkg::S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pptm_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= '0;
         high_ff      <= 28'd64;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (pptm_pkg::csr_type'(csr_index))
               pptm_pkg::CSR_POOL_LOW:  low_ff  <= csr_wdata[FW-1:0];
               default:                 high_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      frame_ff      <= frame_in;
      root_ff       <= root_in;
      va_ff         <= va_in;
      attr_ff       <= attr_in;
      level_ff      <= level_in;
      cur_ff        <= cur_in;
      new_ff        <= new_in;
      slot_ff       <= slot_in;
      clr_ff        <= clr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   pptm_table_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (EW)
   ) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   assign req_tready = (state_ff == pptm_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_frame_ff, rsp_status_ff};

   // The stack never holds more frames than the pool has pages.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_PAGES))
      else $error("free stack count above pool size");

   // A walk never goes below the leaf level.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pptm_pkg::S_WALK_RD) |-> (level_ff != 2'd3))
      else $error("walk level out of range");

   // The table RAM is never written while the unit is idle.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pptm_pkg::S_IDLE) |-> !tbl_we)
      else $error("table write while idle");

   // An accepted item always starts execution on the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == pptm_pkg::S_EXEC))
      else $error("accepted item did not start");

endmodule

// ----- hdl/pptm_table_ram.sv -----
// Single-port-write, single-port-read table entry RAM with registered read data.
// Standalone; sized by the top level.
`timescale 1ns / 1ps

module pptm_table_ram #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int DW    = 39
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for page_pool_and_table_mapper_unit: free stack, allocation,
// three-level map and unmap, checked against an in-bench predictor of the pool and tables.
// Depends on pptm_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int PAGES        = 64;
   localparam int TABLE_SLOTS  = 512;
   localparam int STALL_LIMIT  = 20000;
   localparam int LONG_HOLD    = 2500;
   localparam logic [2:0] WALK_ABSENT = 3'd7;
   localparam logic [26:0] FRAME_MAX  = 27'h7FF_FFFF;

   // One command item together with the result that the predictor expects for it.
   typedef struct {
      pptm_pkg::cmd_type    cmd;
      logic [26:0]          frame;
      logic [26:0]          root;
      logic [47:0]          va;
      logic [9:0]           attr;
      pptm_pkg::status_type status;
      logic [26:0]          frame_out;
   } mapper_cmd;

   typedef struct {
      logic [26:0]   root;
      logic [47:0]   va;
   } live_mapping;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [111:0]   req_tdata = '0;
   logic [1:0]     req_tuser = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [31:0]    rsp_tdata;
   logic           csr_we = 1'b0;
   logic           csr_index = 1'b0;
   logic [27:0]    csr_wdata = '0;

   page_pool_and_table_mapper_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor state: the table store, the free stack and the pool bounds. The
   // flag array records which frames have been cleared by an allocation; the
   // RAM is not cleared at reset, so only those tables may ever be read.
   // ---------------------------------------------------------------------------
   logic [38:0]    tbl_store [0:PAGES*TABLE_SLOTS-1];
   bit             tbl_cleared [0:PAGES-1];
   logic [26:0]    free_frames [0:PAGES-1];
   int unsigned    free_depth = 0;
   logic [26:0]    pool_lo = 27'd0;
   logic [27:0]    pool_hi = 28'd64;

   mapper_cmd      pending_cmds[$];
   mapper_cmd      results_due[$];
   logic [26:0]    table_roots[$];
   live_mapping    mappings[$];

   int             n_accepted = 0;
   int             n_results = 0;
   int             n_errors = 0;

   function automatic logic [14:0] slot_of(logic [26:0] tf, logic [8:0] idx);
      return {tf[5:0], idx};
   endfunction

   function automatic bit frame_in_pool(logic [26:0] f);
      return f >= pool_lo && ({1'b0, f} + 28'd1) <= pool_hi && f < PAGES;
   endfunction

   function automatic pptm_pkg::status_type push_free(logic [26:0] f);
      if (!frame_in_pool(f))
         return pptm_pkg::STS_RANGE;
      if (free_depth >= PAGES)
         return pptm_pkg::STS_FULL;
      free_frames[free_depth] = f;
      free_depth++;
      return pptm_pkg::STS_OK;
   endfunction

   // Pops a frame and clears its table; a frame that fell out of the pool is dropped.
   function automatic pptm_pkg::status_type pop_free(output logic [26:0] f);
      logic [26:0] got;
      f = '0;
      if (free_depth == 0)
         return pptm_pkg::STS_NOMEM;
      free_depth--;
      got = free_frames[free_depth];
      if (!frame_in_pool(got))
         return pptm_pkg::STS_RANGE;
      for (int i = 0; i < TABLE_SLOTS; i++)
         tbl_store[slot_of(got, 9'(i))] = '0;
      tbl_cleared[got[5:0]] = 1'b1;
      f = got;
      return pptm_pkg::STS_OK;
   endfunction

   // One level of the walk: follow a valid entry, or link a fresh table when mapping.
   function automatic logic [2:0] step_level(logic [26:0] tf, logic [8:0] idx, bit grow,
                                             logic [9:0] attr, output logic [26:0] nxt);
      logic [38:0] e;
      logic [26:0] nf;
      pptm_pkg::status_type st;
      e = tbl_store[slot_of(tf, idx)];
      nxt = '0;
      if (e[0]) begin
         nf = e[38:12];
         if (nf >= PAGES)
            return pptm_pkg::STS_RANGE;
         nxt = nf;
         return pptm_pkg::STS_OK;
      end
      if (!grow)
         return WALK_ABSENT;
      st = pop_free(nf);
      if (st != pptm_pkg::STS_OK)
         return st;
      tbl_store[slot_of(tf, idx)] = {nf, attr, pptm_pkg::TYPE_TABLE};
      nxt = nf;
      return pptm_pkg::STS_OK;
   endfunction

   function automatic logic [2:0] walk_tables(logic [26:0] root, logic [47:0] va, bit grow,
                                              logic [9:0] attr, output logic [14:0] leaf);
      logic [26:0] t1, t2;
      logic [2:0]  st;
      leaf = '0;
      if (root >= PAGES)
         return pptm_pkg::STS_RANGE;
      st = step_level(root, va[47:39], grow, attr, t1);
      if (st != pptm_pkg::STS_OK)
         return st;
      st = step_level(t1, va[38:30], grow, attr, t2);
      if (st != pptm_pkg::STS_OK)
         return st;
      leaf = slot_of(t2, va[29:21]);
      return pptm_pkg::STS_OK;
   endfunction

   // Dry run of a walk: true when every table it would read has been cleared.
   // A table allocated on the way is cleared, so everything below it is safe.
   function automatic bit walk_is_defined(logic [26:0] root, logic [47:0] va);
      logic [38:0] e;
      logic [26:0] t;
      if (root >= PAGES)
         return 1'b1;
      if (!tbl_cleared[root[5:0]])
         return 1'b0;
      e = tbl_store[slot_of(root, va[47:39])];
      if (!e[0])
         return 1'b1;
      t = e[38:12];
      if (t >= PAGES)
         return 1'b1;
      if (!tbl_cleared[t[5:0]])
         return 1'b0;
      e = tbl_store[slot_of(t, va[38:30])];
      if (!e[0])
         return 1'b1;
      return e[38:12] >= PAGES || tbl_cleared[e[17:12]];
   endfunction

   // Applies one command to the predicted state and fills in its expected result.
   function automatic mapper_cmd predict_result(mapper_cmd it);
      logic [2:0]  st;
      logic [26:0] f;
      logic [14:0] leaf;
      it.frame_out = '0;
      case (it.cmd)
         pptm_pkg::CMD_FREE:  st = push_free(it.frame);
         pptm_pkg::CMD_ALLOC: begin
            st = pop_free(f);
            if (st == pptm_pkg::STS_OK)
               it.frame_out = f;
         end
         pptm_pkg::CMD_MAP: begin
            if (({1'b0, it.frame} + 28'd1) > pool_hi) begin
               st = pptm_pkg::STS_RANGE;
            end else begin
               st = walk_tables(it.root, it.va, 1'b1, it.attr, leaf);
               if (st == pptm_pkg::STS_OK) begin
                  if (tbl_store[leaf][0])
                     st = pptm_pkg::STS_MAPPED;
                  else
                     tbl_store[leaf] = {it.frame, it.attr, pptm_pkg::TYPE_BLOCK};
               end
            end
         end
         default: begin
            st = walk_tables(it.root, it.va, 1'b0, '0, leaf);
            if (st == WALK_ABSENT) begin
               st = pptm_pkg::STS_OK;
            end else if (st == pptm_pkg::STS_OK && tbl_store[leaf][0]) begin
               st = push_free(tbl_store[leaf][38:12]);
               if (st == pptm_pkg::STS_OK)
                  tbl_store[leaf] = '0;
            end
         end
      endcase
      it.status = pptm_pkg::status_type'(st);
      return it;
   endfunction

   // Predicts an item, queues it for the driver and remembers roots and mappings
   // so that later items can reuse them. Returns the expected result.
   function automatic mapper_cmd queue_cmd(pptm_pkg::cmd_type cmd, logic [26:0] frame,
                                           logic [26:0] root, logic [47:0] va,
                                           logic [9:0] attr);
      mapper_cmd it;
      live_mapping m;
      it.cmd = cmd;
      it.frame = frame;
      it.root = root;
      it.va = va;
      it.attr = attr;
      it = predict_result(it);
      pending_cmds.push_back(it);
      if (cmd == pptm_pkg::CMD_ALLOC && it.status == pptm_pkg::STS_OK)
         table_roots.push_back(it.frame_out);
      if (cmd == pptm_pkg::CMD_MAP && it.status == pptm_pkg::STS_OK) begin
         m.root = root;
         m.va = va;
         mappings.push_back(m);
      end
      return it;
   endfunction

   function automatic logic [8:0] pick_index();
      if ($urandom_range(0, 3) == 0)
         return 9'($urandom);
      return 9'($urandom_range(0, 2)) | ($urandom_range(0, 5) == 0 ? 9'h1ff : 9'h0);
   endfunction

   // Mostly a few shared indices so that tables get reused and entries collide.
   function automatic logic [47:0] pick_vaddr();
      if ($urandom_range(0, 4) == 0)
         return {16'($urandom), 32'($urandom)};
      return {pick_index(), pick_index(), pick_index(), 21'($urandom)};
   endfunction

   function automatic logic [26:0] pick_frame();
      if ($urandom_range(0, 9) == 0)
         return 27'($urandom);
      return 27'($urandom_range(0, PAGES - 1));
   endfunction

   // One random item: frees, allocations, maps over live roots and unmaps of live
   // mappings, with some stray roots and addresses. Walks that would read a table
   // no allocation has cleared are redrawn.
   task automatic queue_random_cmd();
      mapper_cmd         r;
      pptm_pkg::cmd_type cmd;
      logic [26:0]       root;
      logic [47:0]       va;
      live_mapping       m;
      int                sel;
      for (int tries = 0; tries < 20; tries++) begin
         sel = $urandom_range(0, 99);
         cmd = sel < 18 ? pptm_pkg::CMD_FREE : sel < 38 ? pptm_pkg::CMD_ALLOC :
               sel < 75 ? pptm_pkg::CMD_MAP : pptm_pkg::CMD_UNMAP;
         root = table_roots.size() > 0 && $urandom_range(0, 7) != 0 ?
                table_roots[$urandom_range(0, table_roots.size() - 1)] : pick_frame();
         va = pick_vaddr();
         if (cmd == pptm_pkg::CMD_UNMAP && mappings.size() > 0 &&
             $urandom_range(0, 9) < 7) begin
            m = mappings[$urandom_range(0, mappings.size() - 1)];
            root = m.root;
            va = m.va;
         end
         if (cmd == pptm_pkg::CMD_FREE || cmd == pptm_pkg::CMD_ALLOC ||
             walk_is_defined(root, va)) begin
            r = queue_cmd(cmd, pick_frame(), root, va, 10'($urandom));
            return;
         end
      end
      r = queue_cmd(pptm_pkg::CMD_ALLOC, pick_frame(), 27'($urandom), pick_vaddr(),
                    10'($urandom));
   endtask

   // A gap on 16 in 100 draws, except for a stretch where both sides run flat out.
   function automatic bit take_gap(int n);
      return !(n >= 500 && n < 700) && $urandom_range(0, 99) < 16;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offers items from the pending queue and hands each accepted one to
   // the store of results due.
   // ---------------------------------------------------------------------------
   mapper_cmd on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            results_due.push_back(on_bus);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && !take_gap(n_accepted)) begin
               on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.attr, on_bus.va, on_bus.root, on_bus.frame};
               req_tuser <= on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once a few hundred results
   // are in, so that the output register fills and the unit stalls its input.
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_results >= 300) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_gap(n_results);
      end
   end

   // Monitor: each result is checked against the oldest expectation.
   mapper_cmd due;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (results_due.size() == 0) begin
            $error("unexpected result: status %0d frame_out %0d",
                   rsp_tdata[2:0], rsp_tdata[29:3]);
            n_errors++;
         end else begin
            due = results_due.pop_front();
            if (rsp_tdata[2:0] !== due.status) begin
               $error("status: expected %0d, actual %0d", due.status, rsp_tdata[2:0]);
               n_errors++;
            end
            if (rsp_tdata[29:3] !== due.frame_out) begin
               $error("frame_out: expected %0d, actual %0d", due.frame_out,
                      rsp_tdata[29:3]);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either side for too long.
   int stall_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer: directed items, then phases of random items under different
   // pool bounds. Registers change only once the unit has returned every result.
   // ---------------------------------------------------------------------------
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_cmds.size() > 0 || results_due.size() > 0 || req_tvalid);
   endtask

   task automatic write_pool(logic [26:0] lo, logic [27:0] hi);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= pptm_pkg::CSR_POOL_LOW;
      csr_wdata <= {1'b0, lo};
      @(posedge clock);
      csr_index <= pptm_pkg::CSR_POOL_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_lo = lo;
      pool_hi = hi;
   endtask

   logic [26:0] phase_lo [0:6] = '{27'd0, 27'd0, 27'd10, 27'd63, 27'd0, FRAME_MAX, 27'd0};
   logic [27:0] phase_hi [0:6] = '{28'd64, 28'h800_0000, 28'd40, 28'd64, 28'd0,
                                   28'h800_0000, 28'd64};
   int          phase_len [0:6] = '{260, 300, 120, 60, 40, 40, 330};

   initial begin
      mapper_cmd   r;
      logic [26:0] root_a;
      logic [47:0] va_top;

      for (int i = 0; i < PAGES * TABLE_SLOTS; i++)
         tbl_store[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_pool(27'd0, 28'd64);
      @(negedge clock);

      // Directed: empty stack, frees outside the pool, a full walk at the top
      // of the address space, a double map, bound failures, unmap of a live
      // entry, of an invalid entry and of a missing table, and a map that
      // runs out of frames partway.
      va_top = 48'hFFFF_FFFF_FFFF;
      r = queue_cmd(pptm_pkg::CMD_ALLOC, '0, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd64, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, FRAME_MAX, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd0, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd63, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd7, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd8, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_FREE, 27'd9, '0, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_ALLOC, '0, '0, '0, '0);
      root_a = r.frame_out;
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd63, root_a, va_top, 10'h3FF);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd63, root_a, va_top, 10'h155);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd64, root_a, 48'h20_0000, 10'h2AA);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd1, FRAME_MAX, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_UNMAP, '0, root_a, va_top, '0);
      r = queue_cmd(pptm_pkg::CMD_UNMAP, FRAME_MAX, root_a, va_top, 10'h3FF);
      r = queue_cmd(pptm_pkg::CMD_UNMAP, '0, root_a, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd0, root_a, '0, '0);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd5, root_a, 48'h20_0000, 10'h3FF);
      r = queue_cmd(pptm_pkg::CMD_MAP, 27'd6, root_a, 48'h80_0000_0000, 10'h1);
      r = queue_cmd(pptm_pkg::CMD_ALLOC, '0, '0, '0, '0);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         write_pool(phase_lo[p], phase_hi[p]);
         @(negedge clock);
         // With the widest pool, start by overfilling the free stack.
         if (p == 1)
            for (int i = 0; i < 70; i++)
               r = queue_cmd(pptm_pkg::CMD_FREE, 27'($urandom_range(0, PAGES - 1)),
                             '0, '0, '0);
         for (int i = 0; i < phase_len[p]; i++)
            queue_random_cmd();
         wait_drained();
      end

      // Give the unit time to show any stray result before judging the run.
      repeat (50) @(posedge clock);
      if (n_errors == 0 && results_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/pptm_pkg.sv
hdl/pptm_table_ram.sv
hdl/page_pool_and_table_mapper_unit.sv
dv/tb_top.sv
